// File: rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// Cubic curve tessellator package
// Shared types, field layouts and constants for the tessellator blocks.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int DEF_MAX_POINTS  = 64;
  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_MAX_STEPS   = 63;

  localparam int T_W    = 17;  // t in unsigned Q1.16 up to 1.0
  localparam int WGT_W  = 31;  // basis weight, unsigned Q1.30 (at most 1.0)
  localparam int PT_W   = 12;  // point index arithmetic
  localparam int STEP_W = 6;
  localparam int CFG_W  = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_EVAL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE_KIND  = 2'd0,
    CFG_POINT_COUNT = 2'd1,
    CFG_STEPS       = 2'd2,
    CFG_T_INCREMENT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TSTART,
    ST_BASIS,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } cct_state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [5:0]         segment;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_point;
    logic               range_error;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       en;
    logic [1:0] sel;
  } mac_ctrl_t;

endpackage

// File: rtl/cubic_curve_tessellator.sv
// ----------------------------------------------------------------------------
// Cubic curve tessellator
// Control point store with Bezier / uniform B-spline segment evaluation.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_item_i): a load transaction writes
// x, y, z of one control point, a move transaction writes x and y only, and an
// evaluate transaction emits steps+1 curve points on the output channel
// (out_valid_o/out_ready_i, out_item_o), the last one flagged by last_point.
// A segment past the points in use gives one zero point with range_error.
// An evaluate holds the input side until its last point sits in the output
// register. Each point goes through these steps in order: launch t, wait on
// the basis weight pipeline, four reads of the point memory (one control point
// per cycle) feeding the x/y/z MAC lanes, drain, and move the result into the
// output register.
// The output register lets the next transaction enter while the last point
// waits; a stalled receiver holds the sequencer at the output step.
// Reset sets the configuration to Bezier, 4 points, 10 steps, t step 6554.
// The point memories are not cleared; points must be loaded before use.
// ----------------------------------------------------------------------------
module cubic_curve_tessellator #(
  parameter int MAX_POINTS  = cct_pkg::DEF_MAX_POINTS,
  parameter int COORD_WIDTH = cct_pkg::DEF_COORD_WIDTH,
  parameter int MAX_STEPS   = cct_pkg::DEF_MAX_STEPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cct_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cct_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cct_pkg::out_item_t            out_item_o
);
  import cct_pkg::*;

  localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int AW = $clog2(MAX_POINTS);

  // configuration
  logic              curve_kind_q;
  logic [6:0]        point_count_q;
  logic [STEP_W-1:0] steps_q;
  logic [T_W-1:0]    t_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_kind_q  <= 1'b0;
      point_count_q <= 7'd4;
      steps_q       <= STEP_W'(10);
      t_inc_q       <= T_W'(6554);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CURVE_KIND:  curve_kind_q  <= cfg_wdata_i[0];
        CFG_POINT_COUNT: point_count_q <= cfg_wdata_i[6:0];
        CFG_STEPS:       steps_q       <= cfg_wdata_i[STEP_W-1:0];
        CFG_T_INCREMENT: t_inc_q       <= cfg_wdata_i[T_W-1:0];
        default: ;
      endcase
    end
  end

  cct_state_e        state_q, state_d;
  logic [PT_W-1:0]   start_q, start_d;
  logic [STEP_W-1:0] j_q, j_d;
  logic [STEP_W-1:0] last_q, last_d;
  logic              err_q, err_d;
  logic [1:0]        rd_cnt_q, rd_cnt_d;
  logic              rd_vld_q;
  logic [1:0]        rd_sel_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              in_acc;
  logic              st_we, st_we_z;
  logic [PT_W-1:0]   seg_start, count_use;
  logic [STEP_W-1:0] steps_use;
  logic [PT_W-1:0]   rd_pt;
  logic              basis_start, w_valid;
  logic [T_W+STEP_W-1:0] t_prod;
  logic [T_W-1:0]    t_cur;
  logic [WGT_W-1:0]  w [4];
  logic signed [CW-1:0] rd_coord [3];
  logic signed [31:0]   res [3];
  mac_ctrl_t         mac_ctrl;
  logic              out_free;

  assign in_acc    = in_valid_i && in_ready_o;
  assign seg_start = curve_kind_q ? PT_W'(in_item_i.segment)
                                  : PT_W'(3) * PT_W'(in_item_i.segment);
  assign count_use = (PT_W'(point_count_q) < PT_W'(MAX_POINTS)) ? PT_W'(point_count_q)
                                                                  : PT_W'(MAX_POINTS);
  assign steps_use = (steps_q < STEP_W'(MAX_STEPS)) ? steps_q : STEP_W'(MAX_STEPS);
  assign t_prod    = (T_W+STEP_W)'(j_q) * (T_W+STEP_W)'(t_inc_q);
  assign t_cur     = (t_prod > (T_W+STEP_W)'(T_ONE)) ? T_ONE : t_prod[T_W-1:0];
  assign rd_pt     = start_q + PT_W'(rd_cnt_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign st_we   = in_acc && (in_item_i.mode == MODE_LOAD || in_item_i.mode == MODE_MOVE)
                   && (PT_W'(in_item_i.point_index) < PT_W'(MAX_POINTS));
  assign st_we_z = (in_item_i.mode == MODE_LOAD);

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    j_d         = j_q;
    last_d      = last_q;
    err_d       = err_q;
    rd_cnt_d    = rd_cnt_q;
    in_ready_o  = 1'b0;
    basis_start = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.en    = rd_vld_q;
    mac_ctrl.sel   = rd_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_item_i.mode == MODE_EVAL) begin
          start_d = seg_start;
          last_d  = steps_use;
          j_d     = '0;
          if (seg_start + PT_W'(4) > count_use) begin
            err_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            err_d   = 1'b0;
            state_d = ST_TSTART;
          end
        end
      end
      ST_TSTART: begin
        basis_start    = 1'b1;
        mac_ctrl.clear = 1'b1;
        state_d        = ST_BASIS;
      end
      ST_BASIS: begin
        rd_cnt_d = '0;
        if (w_valid) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd3) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_item_d = '{out_x: '0, out_y: '0, out_z: '0,
                           last_point: 1'b1, range_error: 1'b1};
            err_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            out_item_d = '{out_x: res[0], out_y: res[1], out_z: res[2],
                           last_point: (j_q == last_q), range_error: 1'b0};
            if (j_q == last_q) begin
              state_d = ST_IDLE;
            end else begin
              j_d     = j_q + STEP_W'(1);
              state_d = ST_TSTART;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      err_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      rd_vld_q    <= (state_q == ST_MAC);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    j_q        <= j_d;
    last_q     <= last_d;
    rd_cnt_q   <= rd_cnt_d;
    rd_sel_q   <= rd_cnt_q;
    out_item_q <= out_item_d;
  end

  cct_point_store #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .we_z_i  (st_we_z),
    .waddr_i (AW'(in_item_i.point_index)),
    .wx_i    (in_item_i.coord_x[CW-1:0]),
    .wy_i    (in_item_i.coord_y[CW-1:0]),
    .wz_i    (in_item_i.coord_z[CW-1:0]),
    .raddr_i (rd_pt[AW-1:0]),
    .rx_o    (rd_coord[0]),
    .ry_o    (rd_coord[1]),
    .rz_o    (rd_coord[2])
  );

  cct_basis u_basis (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (basis_start),
    .spline_i (curve_kind_q),
    .t_i      (t_cur),
    .valid_o  (w_valid),
    .w_o      (w)
  );

  cct_mac #(
    .CW (CW)
  ) u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .w_i     (w),
    .coord_i (rd_coord),
    .res_o   (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.range_error |-> out_item_o.last_point)
    else $error("range error point not marked last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.range_error |->
      (out_item_o.out_x == 0 && out_item_o.out_y == 0 && out_item_o.out_z == 0))
    else $error("range error point carries coordinates");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_free |=> out_valid_q)
    else $error("result not placed in output register");

  a_mac_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_MAC || state_q == ST_DRAIN))
    else $error("accumulate outside the read walk");

  a_basis_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid |-> state_q == ST_BASIS)
    else $error("weights arrived outside basis wait");

endmodule

// File: rtl/cct_point_store.sv
// ----------------------------------------------------------------------------
// Control point store
// Three synchronous single-port-write memories for x, y and z, registered read.
// ----------------------------------------------------------------------------
module cct_point_store #(
  parameter int MAX_POINTS = cct_pkg::DEF_MAX_POINTS,
  parameter int CW         = 32,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 we_z_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [CW-1:0] wx_i,
  input  logic signed [CW-1:0] wy_i,
  input  logic signed [CW-1:0] wz_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [CW-1:0] rx_o,
  output logic signed [CW-1:0] ry_o,
  output logic signed [CW-1:0] rz_o
);
  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];
  logic signed [CW-1:0] mem_z [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
    if (we_i && we_z_i) begin
      mem_z[waddr_i] <= wz_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
    rz_o <= mem_z[raddr_i];
  end

endmodule

// File: rtl/cct_basis.sv
// ----------------------------------------------------------------------------
// Cubic basis weight pipeline
// Five registered stages from t to the four Q1.30 Bezier or B-spline weights.
// ----------------------------------------------------------------------------
module cct_basis (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    spline_i,
  input  logic [cct_pkg::T_W-1:0] t_i,
  output logic                    valid_o,
  output logic [cct_pkg::WGT_W-1:0] w_o [4]
);
  import cct_pkg::*;

  localparam int P_W = 2 * T_W;
  localparam int C_W = 3 * T_W;
  localparam int B_W = C_W + 2;
  localparam logic [B_W-1:0] BZ_HALF = B_W'(1) << 17;
  localparam logic [B_W-1:0] SP_HALF = B_W'(3) << 18;
  localparam logic [B_W-1:0] FOUR48  = B_W'(4) << 48;
  localparam logic [B_W-1:0] ONE48   = B_W'(1) << 48;
  localparam logic [63:0]    RECIP3  = 64'h0000_0000_AAAA_AAAB;

  logic [4:0] vld_q;

  // stage 1
  logic [T_W-1:0] t1_q, s1_q;
  logic           sp1_q;
  // stage 2
  logic [T_W-1:0] t2a_q, s2a_q;
  logic [P_W-1:0] tt2_q, ss2_q;
  logic           sp2_q;
  // stage 3
  logic [T_W-1:0] t3a_q;
  logic [P_W-1:0] tt3_q;
  logic [C_W-1:0] ttt_q, sss_q, tss_q, tts_q;
  logic           sp3_q;
  // stage 4
  logic [31:0]    n_q [4];
  logic           sp4_q;

  logic [B_W-1:0] b_d [4];
  logic [31:0]    n_d [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= t_i;
    s1_q  <= T_ONE - t_i;
    sp1_q <= spline_i;

    t2a_q <= t1_q;
    s2a_q <= s1_q;
    tt2_q <= P_W'(t1_q) * P_W'(t1_q);
    ss2_q <= P_W'(s1_q) * P_W'(s1_q);
    sp2_q <= sp1_q;

    t3a_q <= t2a_q;
    tt3_q <= tt2_q;
    ttt_q <= C_W'(tt2_q) * C_W'(t2a_q);
    sss_q <= C_W'(ss2_q) * C_W'(s2a_q);
    tss_q <= C_W'(ss2_q) * C_W'(t2a_q);
    tts_q <= C_W'(tt2_q) * C_W'(s2a_q);
    sp3_q <= sp2_q;

    n_q   <= n_d;
    sp4_q <= sp3_q;
  end

  always_comb begin
    if (!sp3_q) begin
      b_d[0] = B_W'(sss_q);
      b_d[1] = B_W'(3) * B_W'(tss_q);
      b_d[2] = B_W'(3) * B_W'(tts_q);
      b_d[3] = B_W'(ttt_q);
      for (int i = 0; i < 4; i++) begin
        n_d[i] = 32'((b_d[i] + BZ_HALF) >> 18);
      end
    end else begin
      b_d[0] = B_W'(sss_q);
      b_d[1] = B_W'(3) * B_W'(ttt_q) + FOUR48 - B_W'(6) * (B_W'(tt3_q) << 16);
      b_d[2] = B_W'(3) * (B_W'(tt3_q) << 16) + B_W'(3) * (B_W'(t3a_q) << 32)
               + ONE48 - B_W'(3) * B_W'(ttt_q);
      b_d[3] = B_W'(ttt_q);
      // divide by 6 << 18: halve here, divide by three in the last stage
      for (int i = 0; i < 4; i++) begin
        n_d[i] = 32'((b_d[i] + SP_HALF) >> 19);
      end
    end
  end

  logic [63:0] q3 [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q3[i] = 64'(n_q[i]) * RECIP3;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      w_o[i] <= sp4_q ? q3[i][33+WGT_W-1:33] : n_q[i][WGT_W-1:0];
    end
  end

  assign valid_o = vld_q[4];

endmodule

// File: rtl/cct_mac.sv
// ----------------------------------------------------------------------------
// Weighted sum lanes
// Three accumulators for x, y, z with rounding and saturation to Q16.16.
// ----------------------------------------------------------------------------
module cct_mac #(
  parameter int CW = 32
) (
  input  logic                        clk_i,
  input  cct_pkg::mac_ctrl_t          ctrl_i,
  input  logic [cct_pkg::WGT_W-1:0]   w_i [4],
  input  logic signed [CW-1:0]        coord_i [3],
  output logic signed [31:0]          res_o [3]
);
  import cct_pkg::*;

  localparam int ACC_W = CW + 34;
  localparam int Q_W   = ACC_W - 30;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << 29;
  localparam logic signed [Q_W-1:0]   SAT_HI = Q_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0]   SAT_LO = Q_W'(-(64'sd1 <<< (CW - 1)));

  logic signed [ACC_W-1:0] acc_q [3];
  logic signed [WGT_W:0]   w_sel;

  assign w_sel = $signed({1'b0, w_i[ctrl_i.sel]});

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [CW+WGT_W:0] prod;
    logic signed [ACC_W-1:0]  v;
    logic signed [Q_W-1:0]    q;
    logic signed [CW-1:0]     sat;

    assign prod = w_sel * coord_i[l];

    always_ff @(posedge clk_i) begin
      if (ctrl_i.clear) begin
        acc_q[l] <= '0;
      end else if (ctrl_i.en) begin
        acc_q[l] <= acc_q[l] + ACC_W'(prod);
      end
    end

    always_comb begin
      v = acc_q[l] + HALF;
      q = $signed(v[ACC_W-1:30]);
      if (q > SAT_HI) begin
        sat = SAT_HI[CW-1:0];
      end else if (q < SAT_LO) begin
        sat = SAT_LO[CW-1:0];
      end else begin
        sat = q[CW-1:0];
      end
      res_o[l] = 32'(sat);
    end
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Cubic curve tessellator testbench
// Loads every control point, then runs evaluate, load, move and ignored
// transactions under several configurations (Bezier and B-spline, point
// counts, step counts, t steps). An internal curve predictor builds the
// expected points and a checker compares every output transaction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cct_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;

  cubic_curve_tessellator dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] pt_x [64];
  logic signed [31:0] pt_y [64];
  logic signed [31:0] pt_z [64];
  bit                 kind_spline = 1'b0;
  int unsigned        used_points = 4;
  int unsigned        seg_steps = 10;
  longint unsigned    t_step = 6554;

  out_item_t curve_points[$];
  int        mismatches = 0;
  bit        steady = 1'b0;

  function automatic void basis_weights(input longint unsigned t, input bit spline,
                                        output longint w [4]);
    longint unsigned s, t2, t3, s2, s3, d, h, b1, b2;
    s  = 65536 - t;
    t2 = t * t;
    t3 = t2 * t;
    s2 = s * s;
    s3 = s2 * s;
    if (!spline) begin
      w[0] = longint'((s3 + (64'd1 << 17)) >> 18);
      w[1] = longint'((3 * t * s2 + (64'd1 << 17)) >> 18);
      w[2] = longint'((3 * t2 * s + (64'd1 << 17)) >> 18);
      w[3] = longint'((t3 + (64'd1 << 17)) >> 18);
    end else begin
      d  = 64'd6 << 18;
      h  = 64'd3 << 18;
      b1 = 3 * t3 + (64'd4 << 48) - 6 * (t2 << 16);
      b2 = 3 * (t2 << 16) + 3 * (t << 32) + (64'd1 << 48) - 3 * t3;
      w[0] = longint'((s3 + h) / d);
      w[1] = longint'((b1 + h) / d);
      w[2] = longint'((b2 + h) / d);
      w[3] = longint'((t3 + h) / d);
    end
  endfunction

  // round half up to Q16.16, then saturate
  function automatic logic [31:0] round_sat(input longint acc);
    longint q;
    q = (acc + (64'sd1 <<< 29)) >>> 30;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic void predict_curve(input in_item_t it);
    int unsigned     first, last_j;
    longint unsigned t;
    longint          w [4];
    longint          ax, ay, az;
    out_item_t       r;
    case (it.mode)
      MODE_LOAD, MODE_MOVE: begin
        pt_x[it.point_index] = it.coord_x;
        pt_y[it.point_index] = it.coord_y;
        if (it.mode == MODE_LOAD) pt_z[it.point_index] = it.coord_z;
      end
      MODE_EVAL: begin
        first = kind_spline ? it.segment : 3 * it.segment;
        if (first + 4 > ((used_points > 64) ? 64 : used_points)) begin
          r = '0;
          r.last_point = 1'b1;
          r.range_error = 1'b1;
          curve_points.push_back(r);
        end else begin
          last_j = seg_steps;
          for (int j = 0; j <= last_j; j++) begin
            t = j * t_step;
            if (t > 65536) t = 65536;
            basis_weights(t, kind_spline, w);
            ax = 0;
            ay = 0;
            az = 0;
            for (int i = 0; i < 4; i++) begin
              ax += w[i] * longint'(pt_x[first + i]);
              ay += w[i] * longint'(pt_y[first + i]);
              az += w[i] * longint'(pt_z[first + i]);
            end
            r.out_x = round_sat(ax);
            r.out_y = round_sat(ay);
            r.out_z = round_sat(az);
            r.last_point = (j == last_j);
            r.range_error = 1'b0;
            curve_points.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (curve_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction %p", out_item_o);
      end else begin
        if (out_item_o !== curve_points[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", curve_points[0], out_item_o);
        end
        void'(curve_points.pop_front());
      end
    end
  end

  always @(posedge clk_i) out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 33);

  task automatic send_item(input in_item_t it);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_curve(it);
  endtask

  // drop valid and wait until the block is idle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (curve_points.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CURVE_KIND:  kind_spline = value[0];
      CFG_POINT_COUNT: used_points = value & 32'h7F;
      CFG_STEPS:       seg_steps = value & 32'h3F;
      default:         t_step = value & 32'h1FFFF;
    endcase
  endtask

  task automatic configure(input bit spline, input int unsigned cnt,
                           input int unsigned steps, input int unsigned tinc);
    wait_idle();
    write_reg(CFG_CURVE_KIND, spline);
    write_reg(CFG_POINT_COUNT, cnt);
    write_reg(CFG_STEPS, steps);
    write_reg(CFG_T_INCREMENT, tinc);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(input mode_e m, input int unsigned idx,
                                         input int unsigned seg);
    in_item_t it;
    it.mode        = m;
    it.point_index = idx[5:0];
    it.coord_x     = rand_coord();
    it.coord_y     = rand_coord();
    it.coord_z     = rand_coord();
    it.segment     = seg[5:0];
    return it;
  endfunction

  task automatic test_load_points();
    in_item_t it;
    for (int i = 0; i < 64; i++) begin
      it = make_item(MODE_LOAD, i, $urandom);
      if (i == 0) begin
        it.coord_x = 32'h7FFF_FFFF;
        it.coord_y = 32'h7FFF_FFFF;
        it.coord_z = 32'h7FFF_FFFF;
      end
      if (i == 1 || i == 2 || i == 3) begin
        it.coord_x = 32'h7FFF_FFFF;
        it.coord_y = 32'h8000_0000;
        it.coord_z = 32'h0000_0000;
      end
      send_item(it);
    end
  endtask

  task automatic test_bezier_directed();
    send_item(make_item(MODE_EVAL, 0, 0));        // reset configuration
    send_item(make_item(MODE_EVAL, 0, 1));        // past point count
    send_item(make_item(MODE_EVAL, 0, 63));
    configure(1'b0, 64, 0, 1);                    // single point at t = 0
    send_item(make_item(MODE_EVAL, 0, 20));
    send_item(make_item(MODE_EVAL, 0, 21));       // start 63 runs past the store
    configure(1'b0, 127, 63, 1040);               // count beyond store, most steps
    send_item(make_item(MODE_EVAL, 0, 0));
    send_item(make_item(MODE_MOVE, 5, 0));
    send_item(make_item(MODE_EVAL, 0, 1));
    configure(1'b0, 64, 5, 131071);               // t clamps to 1.0
    send_item(make_item(MODE_EVAL, 0, 10));
    send_item(make_item(MODE_EVAL, 0, 0));
  endtask

  task automatic test_bspline_directed();
    configure(1'b1, 64, 4, 16384);
    send_item(make_item(MODE_EVAL, 0, 0));
    send_item(make_item(MODE_EVAL, 0, 60));
    send_item(make_item(MODE_EVAL, 0, 61));
    send_item({MODE_EVAL, 6'd0, 96'd0, 6'd63});
    send_item(make_item(mode_e'(2'd3), 7, 0));    // ignored mode
    send_item(make_item(MODE_EVAL, 0, 7));
    configure(1'b1, 4, 1, 65536);
    send_item(make_item(MODE_EVAL, 0, 0));
    send_item(make_item(MODE_EVAL, 0, 1));
  endtask

  task automatic test_random_mix();
    int unsigned cnt, steps, seg_hi, pick;
    bit          spline;
    for (int ph = 0; ph < 8; ph++) begin
      spline = $urandom_range(1);
      cnt    = ($urandom_range(3) == 0) ? $urandom_range(127, 4) : $urandom_range(64, 4);
      steps  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(8);
      configure(spline, cnt, steps,
                ($urandom_range(3) == 0) ? $urandom_range(131071, 1)
                                         : 65536 / ((steps == 0) ? 1 : steps));
      steady = (ph == 3);
      seg_hi = spline ? (((cnt > 64) ? 64 : cnt) - 4)
                      : ((((cnt > 64) ? 64 : cnt) - 4) / 3);
      for (int n = 0; n < 12; n++) begin
        pick = $urandom_range(99);
        if (pick < 45)
          send_item(make_item(MODE_EVAL, 0, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                                     : $urandom_range(seg_hi)));
        else if (pick < 75)
          send_item(make_item(MODE_LOAD, $urandom_range(63), $urandom));
        else if (pick < 95)
          send_item(make_item(MODE_MOVE, $urandom_range(63), $urandom));
        else
          send_item(make_item(mode_e'(2'd3), $urandom_range(63), $urandom));
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_points();
    test_bezier_directed();
    test_bspline_directed();
    test_random_mix();
    wait_idle();
    if (mismatches == 0 && curve_points.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: cubic_curve_tessellator.f
rtl/cct_pkg.sv
rtl/cct_point_store.sv
rtl/cct_basis.sv
rtl/cct_mac.sv
rtl/cubic_curve_tessellator.sv
bench/testbench.sv
